### design/assert_macros.svh
// Assertion macros shared by the tracker RTL.
// Depends on clk_i and rst_ni being visible where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Checked on every clock edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) \
    else $error(msg);

`endif

### design/tcet_pkg.sv
// Shared types and constants for the touch contact event tracker.
// No dependencies; imported by every tracker module.
package tcet_pkg;

  localparam int FieldBits   = 12;
  localparam int ModeBits    = 2;
  localparam int CountBits   = 2;
  localparam int InDataBits  = 56;
  localparam int OutDataBits = 32;

  // Bit offsets of the input fields inside the input tdata.
  localparam int CntLsb = 0;
  localparam int FxLsb  = 2;
  localparam int FyLsb  = 14;
  localparam int SxLsb  = 26;
  localparam int SyLsb  = 38;

  // Listener modes; any other code listens to all pointers.
  localparam logic [ModeBits-1:0] LM_NONE    = 2'd0;
  localparam logic [ModeBits-1:0] LM_PRIMARY = 2'd1;
  localparam logic [ModeBits-1:0] LM_ALL     = 2'd2;

  // Input commands.
  localparam logic CMD_SAMPLE  = 1'b0;
  localparam logic CMD_CONSUME = 1'b1;

  typedef enum logic [1:0] {
    PH_DOWN   = 2'd0,
    PH_MOVE   = 2'd1,
    PH_UP     = 2'd2,
    PH_REPORT = 2'd3
  } phase_e;

  // One pointer event as it leaves the block.
  typedef struct packed {
    phase_e               phase;
    logic                 pointer_id;
    logic                 touching;
    logic [FieldBits-1:0] x;
    logic [FieldBits-1:0] y;
  } evt_t;

  // All events caused by one input item; first is always valid.
  typedef struct packed {
    logic two;
    evt_t first;
    evt_t second;
  } job_t;

  // Write side of the job queue.
  typedef struct packed {
    logic valid;
    job_t job;
  } push_t;

endpackage

### design/tcet_front.sv
// Front end: accepts items, tracks slot state and classifies events into jobs.
// Depends on tcet_pkg.
module tcet_front #(
  parameter int SLOT_COUNT = 2,
  parameter int COORD_BITS = 12
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [tcet_pkg::InDataBits-1:0]  in_data_i,
  input  logic                             in_cmd_i,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [tcet_pkg::ModeBits-1:0]    cfg_data_i,
  output tcet_pkg::push_t                  push_o,
  input  logic                             push_ready_i
);
  import tcet_pkg::*;

  // Slots past the second never become active, so they hold no state.
  localparam int ActSlots = (SLOT_COUNT < 2) ? 1 : 2;
  localparam int CW       = (COORD_BITS < FieldBits) ? COORD_BITS : FieldBits;
  localparam logic [CountBits-1:0] ActCnt = CountBits'(ActSlots);

  typedef logic [CW-1:0] crd_t;

  logic                act_q  [ActSlots];
  logic                act_d  [ActSlots];
  crd_t                lx_q   [ActSlots];
  crd_t                lx_d   [ActSlots];
  crd_t                ly_q   [ActSlots];
  crd_t                ly_d   [ActSlots];
  crd_t                mx_q, mx_d, my_q, my_d;
  logic                queued_q, queued_d;
  logic [ModeBits-1:0] mode_q;

  crd_t                px [2];
  crd_t                py [2];
  logic [CountBits-1:0] n;
  logic [1:0]          ev_cnt;
  evt_t                evs [2];
  logic                accept;

  assign in_ready_o  = push_ready_i;
  assign accept      = in_valid_i && push_ready_i;
  assign cfg_ready_o = 1'b1;

  // Classify the item against the stored slot state.
  always_comb begin
    logic   now;
    logic   allow;
    logic   emit;
    crd_t   cx;
    crd_t   cy;
    phase_e ph;

    px[0] = in_data_i[FxLsb +: CW];
    py[0] = in_data_i[FyLsb +: CW];
    px[1] = in_data_i[SxLsb +: CW];
    py[1] = in_data_i[SyLsb +: CW];

    n = in_data_i[CntLsb +: CountBits];
    if (n > 2'd2) n = 2'd2;
    if (n > ActCnt) n = ActCnt;

    act_d    = act_q;
    lx_d     = lx_q;
    ly_d     = ly_q;
    mx_d     = mx_q;
    my_d     = my_q;
    queued_d = queued_q;
    ev_cnt   = 2'd0;
    evs[0]   = '0;
    evs[1]   = '0;
    now      = 1'b0;
    allow    = 1'b0;
    emit     = 1'b0;
    cx       = '0;
    cy       = '0;
    ph       = PH_DOWN;

    if (in_cmd_i == CMD_CONSUME) begin
      // Consume report goes out whatever the listener mode.
      queued_d          = 1'b0;
      evs[0].phase      = PH_REPORT;
      evs[0].pointer_id = 1'b0;
      evs[0].touching   = 1'b0;
      evs[0].x          = FieldBits'(mx_q);
      evs[0].y          = FieldBits'(my_q);
      ev_cnt            = 2'd1;
    end else begin
      for (int s = 0; s < ActSlots; s++) begin
        now   = (CountBits'(s) < n);
        cx    = now ? px[s] : lx_q[s];
        cy    = now ? py[s] : ly_q[s];
        allow = (mode_q != LM_NONE) && !((mode_q == LM_PRIMARY) && (s != 0));
        emit  = 1'b0;
        ph    = PH_DOWN;
        if (now && !act_q[s]) begin
          emit = 1'b1;
          ph   = PH_DOWN;
          if (s == 0) begin
            mx_d = cx;
            my_d = cy;
          end
        end else if (now && ((cx != lx_q[s]) || (cy != ly_q[s]))) begin
          ph = PH_MOVE;
          if (s == 0) begin
            // Primary moves coalesce until the next consume.
            mx_d     = cx;
            my_d     = cy;
            queued_d = 1'b1;
            emit     = !queued_q;
          end else begin
            emit = 1'b1;
          end
        end else if (!now && act_q[s]) begin
          ph   = PH_UP;
          emit = 1'b1;
        end
        if (emit && allow) begin
          evs[ev_cnt[0]].phase      = ph;
          evs[ev_cnt[0]].pointer_id = (s != 0);
          evs[ev_cnt[0]].touching   = (ph != PH_UP);
          evs[ev_cnt[0]].x          = FieldBits'(cx);
          evs[ev_cnt[0]].y          = FieldBits'(cy);
          ev_cnt                    = ev_cnt + 2'd1;
        end
        if (now) begin
          lx_d[s] = cx;
          ly_d[s] = cy;
        end
        act_d[s] = now;
      end
    end
  end

  // Items whose events are all silenced leave no job behind.
  always_comb begin
    push_o.valid      = in_valid_i && (ev_cnt != 2'd0);
    push_o.job.two    = ev_cnt[1];
    push_o.job.first  = evs[0];
    push_o.job.second = evs[1];
  end

  // Slot and move state, updated on every input transfer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < ActSlots; s++) begin
        act_q[s] <= 1'b0;
        lx_q[s]  <= '0;
        ly_q[s]  <= '0;
      end
      mx_q     <= '0;
      my_q     <= '0;
      queued_q <= 1'b0;
    end else if (accept) begin
      act_q    <= act_d;
      lx_q     <= lx_d;
      ly_q     <= ly_d;
      mx_q     <= mx_d;
      my_q     <= my_d;
      queued_q <= queued_d;
    end
  end

  // Listener mode register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= LM_ALL;
    end else if (cfg_valid_i) begin
      mode_q <= cfg_data_i;
    end
  end

endmodule

### design/tcet_queue.sv
// Short job queue between the front end and the event sequencer.
// Depends on tcet_pkg.
module tcet_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  tcet_pkg::push_t push_i,
  output logic            push_ready_o,
  output logic            head_valid_o,
  output tcet_pkg::job_t  head_o,
  input  logic            pop_i
);
  import tcet_pkg::*;

  localparam int Depth   = 4;
  localparam int PtrBits = $clog2(Depth);
  localparam int CntBits = $clog2(Depth + 1);

  job_t               mem_q [Depth];
  logic [PtrBits-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntBits-1:0] count_q;
  logic               do_push, do_pop;

  assign push_ready_o = (count_q != CntBits'(Depth));
  assign head_valid_o = (count_q != '0);
  assign head_o       = mem_q[rd_ptr_q];
  assign do_push      = push_i.valid && push_ready_o;
  assign do_pop       = pop_i && head_valid_o;

  // Job storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_i.job;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) wr_ptr_q <= wr_ptr_q + PtrBits'(1);
      if (do_pop)  rd_ptr_q <= rd_ptr_q + PtrBits'(1);
      if (do_push && !do_pop) begin
        count_q <= count_q + CntBits'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - CntBits'(1);
      end
    end
  end

endmodule

### design/tcet_back.sv
// Back end: walks the events of each queued job into the output register.
// Depends on tcet_pkg.
module tcet_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           head_valid_i,
  input  tcet_pkg::job_t head_i,
  output logic           pop_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output tcet_pkg::evt_t out_evt_o,
  output logic           out_last_o
);
  import tcet_pkg::*;

  logic out_valid_q;
  evt_t out_evt_q;
  logic out_last_q;
  logic sel_q;
  logic load;
  logic last;
  evt_t cur;

  // Load the next event whenever the output register is free or drains.
  assign load  = head_valid_i && (!out_valid_q || out_ready_i);
  assign cur   = sel_q ? head_i.second : head_i.first;
  assign last  = sel_q || !head_i.two;
  assign pop_o = load && last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      sel_q       <= 1'b0;
    end else if (load) begin
      out_valid_q <= 1'b1;
      sel_q       <= !last;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output payload.
  always_ff @(posedge clk_i) begin
    if (load) begin
      out_evt_q  <= cur;
      out_last_q <= last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_evt_o   = out_evt_q;
  assign out_last_o  = out_last_q;

endmodule

### design/touch_contact_event_tracker_top.sv
// Top level of the two-slot touch contact event tracker.
// Depends on tcet_pkg, tcet_front, tcet_queue, tcet_back and assert_macros.svh.

// Each input transfer is a touch sample (tuser 0) or a consume command (tuser 1).
// A sample yields zero, one or two pointer events (slot 0 first), a consume
// yields one latest-move report; tlast marks the final event of an input.
// The input side takes one item per cycle while the four-entry job queue has
// room. The output register sends one event per cycle while the output port
// is ready, so the output port sets the sustained rate. With the queue empty,
// the first event of an item is written to the job queue and then loaded into
// the output register before it is presented. Listener mode writes are taken
// at any time, but are meant to happen only while the block is idle.
module touch_contact_event_tracker_top #(
  parameter int SLOT_COUNT = 2,
  parameter int COORD_BITS = 12
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // contact_count, first_x, first_y, second_x, second_y, zero fill
  input  logic [tcet_pkg::InDataBits-1:0]    s_axis_tdata_i,
  // command
  input  logic                               s_axis_tuser_i,
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  // pointer_id, touching, event_x, event_y, zero fill
  output logic [tcet_pkg::OutDataBits-1:0]   m_axis_tdata_o,
  // phase
  output logic [1:0]                         m_axis_tuser_o,
  output logic                               m_axis_tlast_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [tcet_pkg::ModeBits-1:0]      cfg_data_i
);
  import tcet_pkg::*;

  push_t push;
  logic  push_ready;
  logic  head_valid;
  job_t  head;
  logic  pop;
  evt_t  out_evt;

  tcet_front #(
    .SLOT_COUNT(SLOT_COUNT),
    .COORD_BITS(COORD_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_data_i   (s_axis_tdata_i),
    .in_cmd_i    (s_axis_tuser_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .push_o      (push),
    .push_ready_i(push_ready)
  );

  tcet_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_ready_o(push_ready),
    .head_valid_o(head_valid),
    .head_o      (head),
    .pop_i       (pop)
  );

  tcet_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_valid_i(head_valid),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_evt_o   (out_evt),
    .out_last_o  (m_axis_tlast_o)
  );

  // Pack the output event onto the stream.
  assign m_axis_tuser_o = out_evt.phase;
  assign m_axis_tdata_o = {
    (OutDataBits - 2 - 2 * FieldBits)'(0),
    out_evt.y, out_evt.x, out_evt.touching, out_evt.pointer_id
  };

  // Checks on the event sequencing.
  `include "assert_macros.svh"

  `ASSERT_ALWAYS(a_idle_in_reset, !rst_ni |-> !m_axis_tvalid_o, "output valid during reset")
  `ASSERT_CLK(a_report_last, m_axis_tvalid_o && (m_axis_tuser_o == PH_REPORT) |-> m_axis_tlast_o, "report not last")
  `ASSERT_CLK(a_up_released, m_axis_tvalid_o && (m_axis_tuser_o == PH_UP) |-> !m_axis_tdata_o[1], "up event touching")
  `ASSERT_CLK(a_run_continues, m_axis_tvalid_o && m_axis_tready_i && !m_axis_tlast_o |=> m_axis_tvalid_o, "second event missing")

endmodule

### tb/tcet_event_checker.sv
`timescale 1ns / 1ps
// Pointer event checker for the touch contact event tracker: watches the
// input, output and listener-mode channels, predicts events and compares them.
// Depends on tcet_pkg.
module tcet_event_checker (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid_i,
  input  logic                               s_axis_tready_o,
  input  logic [tcet_pkg::InDataBits-1:0]    s_axis_tdata_i,
  input  logic                               s_axis_tuser_i,
  input  logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  input  logic [tcet_pkg::OutDataBits-1:0]   m_axis_tdata_o,
  input  logic [1:0]                         m_axis_tuser_o,
  input  logic                               m_axis_tlast_o,
  input  logic                               cfg_valid_i,
  input  logic                               cfg_ready_o,
  input  logic [tcet_pkg::ModeBits-1:0]      cfg_data_i,
  output int                                 mismatch_count_o,
  output int                                 pending_count_o
);
  import tcet_pkg::*;

  localparam int Slots     = 2;
  // Output tdata layout, lowest bit first.
  localparam int EvIdBit   = 0;
  localparam int EvTchBit  = 1;
  localparam int EvXLsb    = 2;
  localparam int EvYLsb    = EvXLsb + FieldBits;
  localparam int EvFillLsb = EvYLsb + FieldBits;
  localparam int FillBits  = OutDataBits - EvFillLsb;

  typedef struct packed {
    phase_e                phase;
    logic                  pointer_id;
    logic                  touching;
    logic [FieldBits-1:0]  x;
    logic [FieldBits-1:0]  y;
    logic                  last;
    logic [FillBits-1:0]   fill;
  } pointer_event_t;

  // Tracker state as this checker sees it.
  logic                 slot_active [Slots];
  logic [FieldBits-1:0] slot_x [Slots];
  logic [FieldBits-1:0] slot_y [Slots];
  logic [FieldBits-1:0] latest_x;
  logic [FieldBits-1:0] latest_y;
  logic                 move_queued;
  logic [ModeBits-1:0]  listen_mode;

  pointer_event_t expected_events [$];

  function automatic string describe(pointer_event_t e);
    return $sformatf("phase=%0d id=%0d touching=%0d x=%0d y=%0d last=%0d fill=%0h",
                     e.phase, e.pointer_id, e.touching, e.x, e.y, e.last, e.fill);
  endfunction

  function automatic pointer_event_t make_event(phase_e ph, int slot, logic tch,
                                                logic [FieldBits-1:0] x,
                                                logic [FieldBits-1:0] y);
    pointer_event_t e;
    e = '0;
    e.phase = ph;
    e.pointer_id = slot[0];
    e.touching = tch;
    e.x = x;
    e.y = y;
    return e;
  endfunction

  // Mode 1 passes slot 0 only, mode 0 nothing; any other code passes all.
  function automatic logic mode_hears(int slot);
    return (listen_mode != LM_NONE) && !(listen_mode == LM_PRIMARY && slot != 0);
  endfunction

  // Updates the slot state for one accepted input and queues its events.
  task automatic predict_pointer_events(input logic cmd,
                                        input logic [CountBits-1:0] cnt,
                                        input logic [FieldBits-1:0] fx,
                                        input logic [FieldBits-1:0] fy,
                                        input logic [FieldBits-1:0] sx,
                                        input logic [FieldBits-1:0] sy);
    pointer_event_t       found [2];
    int                   n_found;
    int                   live;
    logic                 now;
    logic [FieldBits-1:0] in_x [Slots];
    logic [FieldBits-1:0] in_y [Slots];
    logic [FieldBits-1:0] nx;
    logic [FieldBits-1:0] ny;
    n_found = 0;
    if (cmd == CMD_CONSUME) begin
      // A consume always reports, whatever the listener mode.
      move_queued = 1'b0;
      found[0] = make_event(PH_REPORT, 0, 1'b0, latest_x, latest_y);
      n_found = 1;
    end else begin
      live = (cnt > 2'd2) ? 2 : int'(cnt);
      in_x[0] = fx;
      in_y[0] = fy;
      in_x[1] = sx;
      in_y[1] = sy;
      for (int s = 0; s < Slots; s++) begin
        now = (s < live);
        nx = now ? in_x[s] : slot_x[s];
        ny = now ? in_y[s] : slot_y[s];
        if (now && !slot_active[s]) begin
          // A primary down records the position but does not queue a move.
          if (s == 0) begin
            latest_x = nx;
            latest_y = ny;
          end
          if (mode_hears(s)) begin
            found[n_found] = make_event(PH_DOWN, s, 1'b1, nx, ny);
            n_found++;
          end
        end else if (now && (nx != slot_x[s] || ny != slot_y[s])) begin
          // Primary moves coalesce until the next consume.
          if (s == 0) begin
            latest_x = nx;
            latest_y = ny;
          end
          if ((s != 0 || !move_queued) && mode_hears(s)) begin
            found[n_found] = make_event(PH_MOVE, s, 1'b1, nx, ny);
            n_found++;
          end
          if (s == 0) begin
            move_queued = 1'b1;
          end
        end else if (!now && slot_active[s]) begin
          if (mode_hears(s)) begin
            found[n_found] = make_event(PH_UP, s, 1'b0, nx, ny);
            n_found++;
          end
        end
        if (now) begin
          slot_x[s] = nx;
          slot_y[s] = ny;
        end
        slot_active[s] = now;
      end
    end
    for (int i = 0; i < n_found; i++) begin
      found[i].last = (i == n_found - 1);
      expected_events.push_back(found[i]);
    end
  endtask

  // Everything is sampled at the rising edge; the stimulus changes at the
  // falling edge, so the values seen here are the ones of the transfer.
  always @(posedge clk_i or negedge rst_ni) begin
    pointer_event_t got;
    pointer_event_t want;
    if (!rst_ni) begin
      for (int s = 0; s < Slots; s++) begin
        slot_active[s] = 1'b0;
        slot_x[s] = '0;
        slot_y[s] = '0;
      end
      latest_x = '0;
      latest_y = '0;
      move_queued = 1'b0;
      listen_mode = LM_ALL;
      expected_events.delete();
      mismatch_count_o = 0;
      pending_count_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        listen_mode = cfg_data_i;
      end
      // Output transfer: compare against the oldest expected event.
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        got.phase = phase_e'(m_axis_tuser_o);
        got.pointer_id = m_axis_tdata_o[EvIdBit];
        got.touching = m_axis_tdata_o[EvTchBit];
        got.x = m_axis_tdata_o[EvXLsb +: FieldBits];
        got.y = m_axis_tdata_o[EvYLsb +: FieldBits];
        got.last = m_axis_tlast_o;
        got.fill = m_axis_tdata_o[EvFillLsb +: FillBits];
        if (expected_events.size() == 0) begin
          $display("%0t: unexpected pointer event, expected none, actual %s",
                   $time, describe(got));
          mismatch_count_o++;
        end else begin
          want = expected_events.pop_front();
          if (got !== want) begin
            $display("%0t: pointer event mismatch, expected %s, actual %s",
                     $time, describe(want), describe(got));
            mismatch_count_o++;
          end
        end
      end
      // Input transfer: predict the events it causes.
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        predict_pointer_events(s_axis_tuser_i,
                               s_axis_tdata_i[CntLsb +: CountBits],
                               s_axis_tdata_i[FxLsb +: FieldBits],
                               s_axis_tdata_i[FyLsb +: FieldBits],
                               s_axis_tdata_i[SxLsb +: FieldBits],
                               s_axis_tdata_i[SyLsb +: FieldBits]);
      end
      pending_count_o = expected_events.size();
    end
  end

endmodule

### tb/tb_touch_contact_event_tracker_top.sv
`timescale 1ns / 1ps
// Testbench top for the touch contact event tracker: drives samples, consume
// commands and listener-mode writes, and gives the verdict.
// Depends on tcet_pkg, touch_contact_event_tracker_top and tcet_event_checker.
module tb_touch_contact_event_tracker_top;
  import tcet_pkg::*;

  // Mode code 3 is not named by the package; it listens to all pointers.
  localparam logic [ModeBits-1:0] LM_ALL_ALIAS = 2'd3;
  localparam logic [FieldBits-1:0] COORD_MAX   = {FieldBits{1'b1}};
  localparam int RESET_CYCLES  = 9;
  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_CYCLES  = 16;
  localparam int STALL_LIMIT   = 2000;
  localparam int RANDOM_BLOCKS = 12;
  localparam int BLOCK_ITEMS   = 120;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    s_axis_tvalid_i;
  logic                    s_axis_tready_o;
  logic [InDataBits-1:0]   s_axis_tdata_i;
  logic                    s_axis_tuser_i;
  logic                    m_axis_tvalid_o;
  logic                    m_axis_tready_i;
  logic [OutDataBits-1:0]  m_axis_tdata_o;
  logic [1:0]              m_axis_tuser_o;
  logic                    m_axis_tlast_o;
  logic                    cfg_valid_i;
  logic                    cfg_ready_o;
  logic [ModeBits-1:0]     cfg_data_i;
  int                      mismatch_count;
  int                      pending_count;

  int send_idle_pct = 31;
  int recv_idle_pct = 83;

  // Random walk state for well-formed touch sequences.
  logic [CountBits-1:0] walk_cnt;
  logic [FieldBits-1:0] walk_x [2];
  logic [FieldBits-1:0] walk_y [2];

  touch_contact_event_tracker_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i)
  );

  tcet_event_checker checker_inst (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .s_axis_tvalid_i  (s_axis_tvalid_i),
    .s_axis_tready_o  (s_axis_tready_o),
    .s_axis_tdata_i   (s_axis_tdata_i),
    .s_axis_tuser_i   (s_axis_tuser_i),
    .m_axis_tvalid_o  (m_axis_tvalid_o),
    .m_axis_tready_i  (m_axis_tready_i),
    .m_axis_tdata_o   (m_axis_tdata_o),
    .m_axis_tuser_o   (m_axis_tuser_o),
    .m_axis_tlast_o   (m_axis_tlast_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_data_i       (cfg_data_i),
    .mismatch_count_o (mismatch_count),
    .pending_count_o  (pending_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Event receiver: stalls at random on each falling edge.
  initial begin
    m_axis_tready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      m_axis_tready_i <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Watchdog: ends the run when no transfer happens for too long.
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    @(posedge rst_ni);
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("== FAIL ==");
    $finish;
  end

  // Sends one input item, with random idle cycles ahead of it. Returns at the
  // falling edge after the transfer, leaving tvalid high.
  task automatic send_item(input logic cmd, input logic [CountBits-1:0] cnt,
                           input logic [FieldBits-1:0] fx, input logic [FieldBits-1:0] fy,
                           input logic [FieldBits-1:0] sx, input logic [FieldBits-1:0] sy);
    logic [InDataBits-1:0] word;
    word = '0;
    word[CntLsb +: CountBits] = cnt;
    word[FxLsb +: FieldBits] = fx;
    word[FyLsb +: FieldBits] = fy;
    word[SxLsb +: FieldBits] = sx;
    word[SyLsb +: FieldBits] = sy;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i <= word;
    s_axis_tuser_i <= cmd;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Writes the listener mode once every expected event is out and the
  // pipeline has had time to settle.
  task automatic set_listener_mode(input logic [ModeBits-1:0] mode);
    s_axis_tvalid_i <= 1'b0;
    while (pending_count != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= mode;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Mostly touch sequences that evolve from the previous sample, with
  // occasional jumps, saturated counts and consume commands.
  task automatic send_random_touch();
    int                   roll;
    logic [CountBits-1:0] cnt;
    roll = $urandom_range(0, 99);
    if (roll < 9) begin
      send_item(CMD_CONSUME, CountBits'($urandom), FieldBits'($urandom), FieldBits'($urandom),
                FieldBits'($urandom), FieldBits'($urandom));
    end else begin
      roll = $urandom_range(0, 99);
      if (roll < 55) begin
        cnt = walk_cnt;
      end else if (roll < 94) begin
        cnt = CountBits'($urandom_range(0, 2));
      end else begin
        cnt = 2'd3;
      end
      for (int k = 0; k < 2; k++) begin
        roll = $urandom_range(0, 99);
        if (roll < 45) begin
          walk_x[k] = walk_x[k] + FieldBits'($urandom_range(0, 16)) - FieldBits'(8);
          walk_y[k] = walk_y[k] + FieldBits'($urandom_range(0, 16)) - FieldBits'(8);
        end else if (roll < 60) begin
          walk_x[k] = FieldBits'($urandom);
          walk_y[k] = FieldBits'($urandom);
        end else if (roll < 66) begin
          walk_x[k] = {FieldBits{1'($urandom_range(0, 1))}};
          walk_y[k] = {FieldBits{1'($urandom_range(0, 1))}};
        end
      end
      walk_cnt = cnt;
      send_item(CMD_SAMPLE, cnt, walk_x[0], walk_y[0], walk_x[1], walk_y[1]);
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i = '0;
    s_axis_tuser_i = CMD_SAMPLE;
    cfg_valid_i = 1'b0;
    cfg_data_i = LM_ALL;
    walk_cnt = '0;
    for (int k = 0; k < 2; k++) begin
      walk_x[k] = '0;
      walk_y[k] = '0;
    end
    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed part, all pointers heard (reset mode).
    send_item(CMD_SAMPLE, 2'd0, '0, '0, '0, '0);               // nothing happens
    send_item(CMD_CONSUME, 2'd0, '0, '0, '0, '0);              // report of reset position
    send_item(CMD_SAMPLE, 2'd1, '0, '0, '0, '0);               // primary down at origin
    send_item(CMD_SAMPLE, 2'd1, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
    send_item(CMD_SAMPLE, 2'd1, 12'd100, 12'd200, '0, '0);     // coalesced, silent
    send_item(CMD_CONSUME, 2'd0, '0, '0, '0, '0);
    send_item(CMD_SAMPLE, 2'd2, 12'd100, 12'd200, COORD_MAX, '0);
    send_item(CMD_SAMPLE, 2'd3, '0, COORD_MAX, '0, COORD_MAX); // count saturates
    send_item(CMD_SAMPLE, 2'd2, '0, COORD_MAX, '0, COORD_MAX); // unchanged
    send_item(CMD_SAMPLE, 2'd1, '0, COORD_MAX, COORD_MAX, COORD_MAX);
    send_item(CMD_SAMPLE, 2'd0, COORD_MAX, '0, COORD_MAX, '0);
    send_item(CMD_SAMPLE, 2'd2, 12'd5, 12'd6, 12'd7, 12'd8);   // two downs
    send_item(CMD_SAMPLE, 2'd2, 12'd9, 12'd6, 12'd7, 12'd8);   // move still queued
    send_item(CMD_CONSUME, 2'd3, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
    send_item(CMD_SAMPLE, 2'd0, 12'hA5A, 12'h5A5, 12'h5A5, 12'hA5A);

    // Primary pointer only: slot 1 events are dropped, state still tracks.
    set_listener_mode(LM_PRIMARY);
    send_item(CMD_SAMPLE, 2'd2, 12'd10, 12'd20, 12'd30, 12'd40);
    send_item(CMD_SAMPLE, 2'd2, 12'd11, 12'd20, 12'd31, 12'd40);
    send_item(CMD_SAMPLE, 2'd1, 12'd11, 12'd20, 12'd31, 12'd40);
    send_item(CMD_CONSUME, 2'd0, '0, '0, '0, '0);

    // No listener: only consume reports come out.
    set_listener_mode(LM_NONE);
    send_item(CMD_SAMPLE, 2'd0, '0, '0, '0, '0);
    send_item(CMD_CONSUME, 2'd0, '0, '0, '0, '0);

    // Random part in blocks, each under its own listener mode and idle pattern.
    for (int blk = 0; blk < RANDOM_BLOCKS; blk++) begin
      case (blk % 4)
        0: set_listener_mode(LM_ALL_ALIAS);
        1: set_listener_mode(LM_NONE);
        2: set_listener_mode(LM_ALL);
        default: set_listener_mode(LM_PRIMARY);
      endcase
      if (blk < RANDOM_BLOCKS / 3) begin
        send_idle_pct = 31;
        recv_idle_pct = 83;
      end else if (blk < 2 * RANDOM_BLOCKS / 3) begin
        send_idle_pct = 83;
        recv_idle_pct = 31;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      for (int i = 0; i < BLOCK_ITEMS; i++) begin
        send_random_touch();
      end
    end

    // Drain the remaining events, then allow for any stray ones.
    s_axis_tvalid_i <= 1'b0;
    while (pending_count != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+design
design/tcet_pkg.sv
design/tcet_front.sv
design/tcet_queue.sv
design/tcet_back.sv
design/touch_contact_event_tracker_top.sv
tb/tcet_event_checker.sv
tb/tb_touch_contact_event_tracker_top.sv
